// File: hdl/hit_pkg.sv
// hit_pkg: sizes, opcodes, status codes and controller/datapath types
// for the handle index table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hit_pkg;

  // table sizes
  localparam int unsigned SLOT_DEPTH    = 64;
  localparam int unsigned BUILTIN_DEPTH = 64;
  localparam int unsigned MAX_DEPTH     =
      (SLOT_DEPTH > BUILTIN_DEPTH) ? SLOT_DEPTH : BUILTIN_DEPTH;

  localparam int unsigned SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int unsigned BUILTIN_AW = $clog2(BUILTIN_DEPTH);
  localparam int unsigned CNT_W      = $clog2(BUILTIN_DEPTH + 1);
  localparam int unsigned POS_W      = $clog2(MAX_DEPTH);
  localparam int unsigned SCAN_W     = $clog2(MAX_DEPTH + 1);

  localparam int unsigned HANDLE_W = 64;

  // opcodes
  localparam logic [2:0] OP_FIND_INDEX = 3'd0;
  localparam logic [2:0] OP_TO_HANDLE  = 3'd1;
  localparam logic [2:0] OP_ADD        = 3'd2;
  localparam logic [2:0] OP_REMOVE     = 3'd3;
  localparam logic [2:0] OP_APPEND     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic signed [7:0] IDX_NONE = -8'sd1;

  // which result the datapath produces this cycle
  typedef enum logic [2:0] {
    RES_NONE,
    RES_BHIT,
    RES_SHIT,
    RES_MISS,
    RES_HANDLE,
    RES_EXEC
  } res_e;

  typedef struct packed {
    logic load;     // capture the input beat, clear the scan
    logic bscan;    // step the builtin scan
    logic sscan;    // step the slot scan
    logic restart;  // clear the scan pointer between phases
    logic hread;    // read both stores at the requested index
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic b_hit;
    logic b_end;
    logic s_hit;
    logic s_end;
  } stat_t;

  // index modulo slot depth, restoring subtraction over the eight index bits
  function automatic logic [SLOT_AW-1:0] slot_of_index(input logic [7:0] idx);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(idx);
    for (int k = 7; k >= 0; k--) begin
      m = 32'(SLOT_DEPTH) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[SLOT_AW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/hit_ram.sv
// hit_ram: generic single-write, single-read RAM with registered read data.
// Self-contained, no package.
`timescale 1ns / 1ps
`default_nettype none
module hit_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/hit_ctrl.sv
// hit_ctrl: one-hot sequencer for the handle index table.
// Depends on hit_pkg; drives hit_dpath through cmd_t, reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module hit_ctrl
  import hit_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [2:0] opcode_i,
  input  wire stat_t      stat_i,
  output cmd_t            cmd_o,
  output logic            busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BSCAN = 6'b000010,
    S_SSCAN = 6'b000100,
    S_HRD   = 6'b001000,
    S_HCHK  = 6'b010000,
    S_EXEC  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.bscan   = 1'b0;
    cmd_o.sscan   = 1'b0;
    cmd_o.restart = 1'b0;
    cmd_o.hread   = 1'b0;
    cmd_o.res     = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            OP_FIND_INDEX: state_d = S_BSCAN;
            OP_TO_HANDLE:  state_d = S_HRD;
            OP_REMOVE:     state_d = S_SSCAN;
            default:       state_d = S_EXEC;
          endcase
        end
      end
      S_BSCAN: begin
        cmd_o.bscan = 1'b1;
        if (stat_i.b_hit) begin
          cmd_o.res = RES_BHIT;
          state_d   = S_IDLE;
        end else if (stat_i.b_end) begin
          cmd_o.restart = 1'b1;
          state_d       = S_SSCAN;
        end
      end
      S_SSCAN: begin
        cmd_o.sscan = 1'b1;
        if (stat_i.s_hit) begin
          cmd_o.res = RES_SHIT;
          state_d   = S_IDLE;
        end else if (stat_i.s_end) begin
          cmd_o.res = RES_MISS;
          state_d   = S_IDLE;
        end
      end
      S_HRD: begin
        cmd_o.hread = 1'b1;
        state_d     = S_HCHK;
      end
      S_HCHK: begin
        cmd_o.res = RES_HANDLE;
        state_d   = S_IDLE;
      end
      S_EXEC: begin
        cmd_o.res = RES_EXEC;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/hit_dpath.sv
// hit_dpath: stores, scan pointer, compare and result registers.
// Depends on hit_pkg and hit_ram; commanded by hit_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module hit_dpath
  import hit_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  input  wire logic [2:0]           opcode_i,
  input  wire logic [HANDLE_W-1:0]  handle_value_i,
  input  wire logic [7:0]           table_index_i,
  output stat_t                     stat_o,
  output logic signed [7:0]         mapped_index_o,
  output logic [HANDLE_W-1:0]       mapped_handle_o,
  output logic [1:0]                status_o,
  output logic                      done_o
);

  // captured beat
  logic [2:0]          op_q;
  logic [HANDLE_W-1:0] h_q;
  logic [7:0]          idx_q;

  // persistent state
  logic [SLOT_DEPTH-1:0] valid_q;
  logic [SLOT_AW-1:0]    wp_q;
  logic [CNT_W-1:0]      count_q;
  logic [HANDLE_W-1:0]   null_q;

  // scan state
  logic [SCAN_W-1:0] ptr_q;
  logic              pend_q;
  logic [POS_W-1:0]  pos_q;

  // results
  logic signed [7:0]   r_index_q;
  logic [HANDLE_W-1:0] r_handle_q;
  logic [1:0]          r_status_q;
  logic                done_q;

  logic [HANDLE_W-1:0] b_rdata, s_rdata;
  logic [BUILTIN_AW-1:0] b_raddr, b_waddr;
  logic [SLOT_AW-1:0]    s_raddr, s_idx, pos_slot;
  logic                  b_we, s_we;
  logic [31:0]           idx_w, pos_w, pos_plus_w, count_w, ptr_w;
  logic                  full, b_more, s_more;
  logic [HANDLE_W-1:0]   s_eff, b_sel, h_sel, hs_eff;

  // widened views for compares
  assign idx_w      = 32'(idx_q);
  assign pos_w      = 32'(pos_q);
  assign count_w    = 32'(count_q);
  assign ptr_w      = 32'(ptr_q);
  assign pos_slot   = pos_q[SLOT_AW-1:0];
  assign pos_plus_w = 32'(pos_slot) + 32'(SLOT_DEPTH);
  assign s_idx      = slot_of_index(idx_q);

  assign full   = (count_w >= 32'(BUILTIN_DEPTH));
  assign b_more = (ptr_w < count_w);
  assign s_more = (ptr_w < 32'(SLOT_DEPTH));

  // memory addressing
  assign b_raddr = cmd_i.hread ? idx_q[BUILTIN_AW-1:0] : ptr_q[BUILTIN_AW-1:0];
  assign s_raddr = cmd_i.hread ? s_idx : ptr_q[SLOT_AW-1:0];
  assign b_waddr = count_q[BUILTIN_AW-1:0];
  assign b_we    = (cmd_i.res == RES_EXEC) && (op_q == OP_APPEND) && !full;
  assign s_we    = (cmd_i.res == RES_EXEC) && (op_q == OP_ADD);

  hit_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (BUILTIN_DEPTH)
  ) u_builtin_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (h_q),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  hit_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (wp_q),
    .wdata_i (h_q),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // empty slots read as the null handle
  assign s_eff  = valid_q[pos_slot] ? s_rdata : null_q;
  assign hs_eff = valid_q[s_idx] ? s_rdata : null_q;
  assign b_sel  = (idx_w < count_w) ? b_rdata : null_q;
  assign h_sel  = (b_sel != null_q) ? b_sel : hs_eff;

  // scan status
  assign stat_o.b_hit = pend_q && (b_rdata == h_q);
  assign stat_o.b_end = !pend_q && !b_more;
  assign stat_o.s_hit = pend_q && (s_eff == h_q);
  assign stat_o.s_end = !pend_q && !s_more;

  // control state: scan, valid bits, pointer, count, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
      wp_q    <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.res != RES_NONE);
      if (cmd_i.load || cmd_i.restart) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
      end else if ((cmd_i.bscan && b_more) || (cmd_i.sscan && s_more)) begin
        ptr_q  <= ptr_q + 1'b1;
        pend_q <= 1'b1;
      end else if (cmd_i.bscan || cmd_i.sscan) begin
        pend_q <= 1'b0;
      end
      if (s_we) begin
        valid_q[wp_q] <= 1'b1;
        wp_q <= (32'(wp_q) == 32'(SLOT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if ((cmd_i.res == RES_SHIT) && (op_q == OP_REMOVE)) begin
        valid_q[pos_slot] <= 1'b0;
      end
      if (b_we) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // payload: beat capture, scan position, null handle, results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      h_q   <= handle_value_i;
      idx_q <= table_index_i;
    end
    if (!cmd_i.load && !cmd_i.restart &&
        ((cmd_i.bscan && b_more) || (cmd_i.sscan && s_more))) begin
      pos_q <= ptr_q[POS_W-1:0];
    end
    if (b_we && (count_q == '0)) begin
      null_q <= h_q;
    end
    case (cmd_i.res)
      RES_BHIT: begin
        r_index_q  <= pos_w[7:0];
        r_handle_q <= '0;
        r_status_q <= ST_OK;
      end
      RES_SHIT: begin
        r_index_q  <= (op_q == OP_REMOVE) ? 8'sd0 : pos_plus_w[7:0];
        r_handle_q <= '0;
        r_status_q <= ST_OK;
      end
      RES_MISS: begin
        r_index_q  <= (op_q == OP_FIND_INDEX) ? IDX_NONE : 8'sd0;
        r_handle_q <= '0;
        r_status_q <= ST_MISSING;
      end
      RES_HANDLE: begin
        r_index_q  <= 8'sd0;
        r_handle_q <= h_sel;
        r_status_q <= ST_OK;
      end
      RES_EXEC: begin
        r_index_q  <= 8'sd0;
        r_handle_q <= '0;
        r_status_q <= ((op_q == OP_APPEND) && full) ? ST_FULL : ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign mapped_index_o  = r_index_q;
  assign mapped_handle_o = r_handle_q;
  assign status_o        = r_status_q;
  assign done_o          = done_q;

endmodule
`default_nettype wire

// File: hdl/handle_index_table.sv
// handle_index_table: top level, joins the sequencer and the datapath.
// Depends on hit_pkg, hit_ctrl, hit_dpath (and hit_ram below it).
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  command   | start in, busy out     | opcode_i, handle_value_i,
//            |                        | table_index_i
//  result    | done_o strobe, 1 cycle | mapped_index_o, mapped_handle_o,
//            |                        | status_o
//
// a beat is taken at an edge with start high and busy low; one result per beat
// handle to index scans the builtin ram, then the slot ram, one entry a cycle,
//   stopping at the first hit; remove scans the slot ram only; index to handle
//   reads both stores at the index, then checks them; add and append go straight
//   to their write
// the strobe follows the last working cycle; the next beat may enter with it
// reset clears slot valid bits, write pointer and builtin count; no sweep
// the receiver cannot stall, so done_o is never held
`timescale 1ns / 1ps
`default_nettype none
module handle_index_table
  import hit_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          opcode_i,
  input  wire logic [HANDLE_W-1:0] handle_value_i,
  input  wire logic [7:0]          table_index_i,
  output logic signed [7:0]        mapped_index_o,
  output logic [HANDLE_W-1:0]      mapped_handle_o,
  output logic [1:0]               status_o,
  output logic                     done_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  hit_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // stores and compare
  hit_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (opcode_i),
    .handle_value_i  (handle_value_i),
    .table_index_i   (table_index_i),
    .stat_o          (stat),
    .mapped_index_o  (mapped_index_o),
    .mapped_handle_o (mapped_handle_o),
    .status_o        (status_o),
    .done_o          (done_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for handle_index_table; a directed table of beats, then random
// beats, checked against a behavioural copy of the builtin and slot tables or a fixed answer.
// Depends on hit_pkg and the handle_index_table rtl.
`timescale 1ns / 1ps
module tb_top;
  import hit_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [HANDLE_W-1:0] ALL_ONES = '1;
  localparam int unsigned RANDOM_BEATS = 1050;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 140;
  localparam int unsigned POOL_SIZE    = 48;

  typedef struct packed {
    logic signed [7:0]   index;
    logic [HANDLE_W-1:0] handle;
    logic [1:0]          status;
  } lookup_t;

  typedef struct {
    logic [2:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [7:0]          index;
    bit                  fixed;
    lookup_t             result;
  } beat_row_t;

  // dut ports
  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              opcode_i;
  logic [HANDLE_W-1:0]     handle_value_i;
  logic [7:0]              table_index_i;
  logic signed [7:0]       mapped_index_o;
  logic [HANDLE_W-1:0]     mapped_handle_o;
  logic [1:0]              status_o;
  logic                    done_o;

  // shadow copy of the tables
  logic [HANDLE_W-1:0] slot_handle [SLOT_DEPTH];
  bit                  slot_full [SLOT_DEPTH];
  int unsigned         wr_ptr = 0;
  logic [HANDLE_W-1:0] builtin_handle [BUILTIN_DEPTH];
  int unsigned         builtin_cnt = 0;

  lookup_t             pending_results [$];
  beat_row_t           directed_rows [$];
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  int unsigned         idle_pct = 37;

  handle_index_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .handle_value_i  (handle_value_i),
    .table_index_i   (table_index_i),
    .mapped_index_o  (mapped_index_o),
    .mapped_handle_o (mapped_handle_o),
    .status_o        (status_o),
    .done_o          (done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // an empty slot reads as builtin entry 0, the null handle
  function automatic logic [HANDLE_W-1:0] slot_read(input int unsigned s);
    return slot_full[s] ? slot_handle[s] : builtin_handle[0];
  endfunction

  // lowest slot holding h, or -1
  function automatic int first_slot(input logic [HANDLE_W-1:0] h);
    for (int s = 0; s < SLOT_DEPTH; s++) begin
      if (slot_read(s) == h) begin
        return s;
      end
    end
    return -1;
  endfunction

  // result of one beat, updating the shadow tables
  function automatic lookup_t table_lookup(input logic [2:0] op, input logic [HANDLE_W-1:0] h,
                                           input logic [7:0] idx);
    lookup_t             r;
    int                  pos;
    logic [HANDLE_W-1:0] b;
    r = '0;
    pos = -1;
    case (op)
      OP_FIND_INDEX: begin
        // builtins take priority over slots
        for (int k = 0; k < int'(builtin_cnt) && pos < 0; k++) begin
          if (builtin_handle[k] == h) begin
            pos = k;
          end
        end
        if (pos >= 0) begin
          r.index = 8'(pos);
        end else begin
          pos = first_slot(h);
          if (pos >= 0) begin
            r.index = 8'(pos + int'(SLOT_DEPTH));
          end else begin
            r.index  = IDX_NONE;
            r.status = ST_MISSING;
          end
        end
      end
      OP_TO_HANDLE: begin
        b = (idx < builtin_cnt) ? builtin_handle[idx] : builtin_handle[0];
        r.handle = (b != builtin_handle[0]) ? b : slot_read(idx % SLOT_DEPTH);
      end
      OP_ADD: begin
        slot_handle[wr_ptr] = h;
        slot_full[wr_ptr]   = 1'b1;
        wr_ptr = (wr_ptr + 1) % SLOT_DEPTH;
      end
      OP_REMOVE: begin
        pos = first_slot(h);
        if (pos >= 0) begin
          slot_full[pos] = 1'b0;
        end else begin
          r.status = ST_MISSING;
        end
      end
      OP_APPEND: begin
        if (builtin_cnt < BUILTIN_DEPTH) begin
          builtin_handle[builtin_cnt] = h;
          builtin_cnt++;
        end else begin
          r.status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // directed table entry; fixed rows carry their own answer
  task automatic add_row(input logic [2:0] op, input logic [HANDLE_W-1:0] h,
                         input logic [7:0] idx, input bit fixed,
                         input logic signed [7:0] index, input logic [HANDLE_W-1:0] handle,
                         input logic [1:0] status);
    beat_row_t row;
    row.op            = op;
    row.handle        = h;
    row.index         = idx;
    row.fixed         = fixed;
    row.result.index  = index;
    row.result.handle = handle;
    row.result.status = status;
    directed_rows = {directed_rows, row};
  endtask

  // offer one command beat, with random idle cycles first; start stays high on back to back beats
  task automatic send_beat(input logic [2:0] op, input logic [HANDLE_W-1:0] h,
                           input logic [7:0] idx, input bit fixed, input lookup_t fixed_result);
    lookup_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    handle_value_i <= h;
    table_index_i  <= idx;
    do @(posedge clk_i); while (busy);
    predicted = table_lookup(op, h, idx);
    pending_results = {pending_results, (fixed ? fixed_result : predicted)};
  endtask

  // result checker: the receiver cannot stall, every strobe is a beat
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, index %0d handle %h status %0d", $time,
                 mapped_index_o, mapped_handle_o, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (mapped_index_o !== want.index) begin
          $display("%0t: mapped_index expected %0d got %0d", $time, want.index,
                   mapped_index_o);
          mismatches++;
        end
        if (mapped_handle_o !== want.handle) begin
          $display("%0t: mapped_handle expected %h got %h", $time, want.handle,
                   mapped_handle_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [2:0]          op;
    logic [HANDLE_W-1:0] h;
    logic [7:0]          idx;
    int unsigned         roll;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    opcode_i       <= OP_FIND_INDEX;
    handle_value_i <= '0;
    table_index_i  <= '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      handle_pool[k] = {$urandom, $urandom};
    end
    handle_pool[0] = '0;
    handle_pool[1] = ALL_ONES;

    // builtins first so that the null handle exists before any lookup
    add_row(OP_APPEND,     '0,       8'd0,   1, 8'sd0,    '0,       ST_OK);
    add_row(OP_APPEND,     ALL_ONES, 8'd0,   1, 8'sd0,    '0,       ST_OK);
    add_row(OP_APPEND,     64'h0123_4567_89ab_cdef, 8'd0, 0, 8'sd0, '0, ST_OK);
    add_row(OP_FIND_INDEX, '0,       8'd0,   1, 8'sd0,    '0,       ST_OK);
    add_row(OP_FIND_INDEX, ALL_ONES, 8'd0,   1, 8'sd1,    '0,       ST_OK);
    // absent handle, empty slots compare as null
    add_row(OP_FIND_INDEX, 64'hdead_beef, 8'd0, 1, IDX_NONE, '0,    ST_MISSING);
    add_row(OP_TO_HANDLE,  '0,       8'd1,   1, 8'sd0,    ALL_ONES, ST_OK);
    add_row(OP_TO_HANDLE,  '0,       8'd0,   1, 8'sd0,    '0,       ST_OK);
    // index past the builtins falls through to an empty slot
    add_row(OP_TO_HANDLE,  ALL_ONES, 8'd255, 1, 8'sd0,    '0,       ST_OK);
    add_row(OP_ADD,        64'ha5a5_a5a5_a5a5_a5a5, 8'd0, 1, 8'sd0, '0, ST_OK);
    add_row(OP_ADD,        64'h5a5a_5a5a_5a5a_5a5a, 8'd0, 0, 8'sd0, '0, ST_OK);
    add_row(OP_ADD,        ALL_ONES, 8'd0,   0, 8'sd0,    '0,       ST_OK);
    add_row(OP_FIND_INDEX, 64'ha5a5_a5a5_a5a5_a5a5, 8'd0, 1, 8'sd64, '0, ST_OK);
    add_row(OP_FIND_INDEX, 64'h5a5a_5a5a_5a5a_5a5a, 8'd0, 0, 8'sd0, '0, ST_OK);
    // builtin wins over a slot holding the same handle
    add_row(OP_FIND_INDEX, ALL_ONES, 8'd0,   1, 8'sd1,    '0,       ST_OK);
    add_row(OP_TO_HANDLE,  '0,       8'd65,  0, 8'sd0,    '0,       ST_OK);
    add_row(OP_TO_HANDLE,  '0,       8'd2,   0, 8'sd0,    '0,       ST_OK);
    // duplicate in a later slot, remove takes the lowest
    add_row(OP_ADD,        64'h5a5a_5a5a_5a5a_5a5a, 8'd0, 0, 8'sd0, '0, ST_OK);
    add_row(OP_REMOVE,     64'h5a5a_5a5a_5a5a_5a5a, 8'd0, 0, 8'sd0, '0, ST_OK);
    add_row(OP_FIND_INDEX, 64'h5a5a_5a5a_5a5a_5a5a, 8'd0, 0, 8'sd0, '0, ST_OK);
    add_row(OP_REMOVE,     64'hbeef, 8'd0,   1, 8'sd0,    '0,       ST_MISSING);
    // null handle matches the emptied slot
    add_row(OP_REMOVE,     '0,       8'd0,   0, 8'sd0,    '0,       ST_OK);
    add_row(OP_SPARE_LO,   ALL_ONES, 8'd255, 1, 8'sd0,    '0,       ST_OK);
    add_row(OP_SPARE_HI,   ALL_ONES, 8'd255, 1, 8'sd0,    '0,       ST_OK);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].handle, directed_rows[i].index,
                directed_rows[i].fixed, directed_rows[i].result);
    end

    // random beats, handles mostly from a small pool so lookups hit
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      idle_pct = (n >= 400 && n < 600) ? 0 : 37;
      // hold off until the table has answered everything
      if (n % 300 == 150) begin
        while (pending_results.size() != 0) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 28) begin
        op = OP_FIND_INDEX;
      end else if (roll < 46) begin
        op = OP_TO_HANDLE;
      end else if (roll < 68) begin
        op = OP_ADD;
      end else if (roll < 80) begin
        op = OP_REMOVE;
      end else if (roll < 95) begin
        op = OP_APPEND;
      end else begin
        op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      if ($urandom_range(0, 9) < 7 && !(op == OP_APPEND && $urandom_range(0, 1) != 0)) begin
        h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        h = {$urandom, $urandom};
      end
      if ($urandom_range(0, 1) != 0) begin
        idx = 8'($urandom_range(0, 255));
      end else begin
        idx = 8'($urandom_range(0, 2 * builtin_cnt));
      end
      // no lookup may touch the null handle before it exists
      if (builtin_cnt == 0 && op != OP_ADD && op <= OP_APPEND) begin
        op = OP_APPEND;
      end
      send_beat(op, h, idx, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
